// ===== hdl/sdat_pkg.sv =====
package sdat_pkg;

    localparam int SENSOR_W = 3;
    localparam int SAMPLE_W = 32;
    localparam int MASK_W   = 5;
    localparam int DEST_W   = 3;

    localparam int SENSOR_COUNT_DEF = 8;
    localparam int DEST_COUNT_DEF   = 5;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

// ===== hdl/sdat_if.sv =====
interface sdat_in_if import sdat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SENSOR_W-1:0] sensor;
    logic [SAMPLE_W-1:0] sample_value;
    logic                average_enable;
    logic [MASK_W-1:0]   dest_mask;

    modport source (
        output valid, op, sensor, sample_value, average_enable, dest_mask,
        input  ready
    );
    modport sink (
        input  valid, op, sensor, sample_value, average_enable, dest_mask,
        output ready
    );
endinterface

interface sdat_out_if import sdat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DEST_W-1:0]   destination;
    logic [SAMPLE_W-1:0] read_value;
    logic                last;

    modport source (
        output valid, destination, read_value, last,
        input  ready
    );
    modport sink (
        input  valid, destination, read_value, last,
        output ready
    );
endinterface

// ===== hdl/sdat_mem.sv =====
module sdat_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_row
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // rows never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/sdat_upd.sv =====
module sdat_upd import sdat_pkg::*; #(
    parameter int DEST_COUNT  = DEST_COUNT_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int EW          = DATA_WIDTH + 1 + COUNT_WIDTH
) (
    input  logic                     op,
    input  logic [DATA_WIDTH-1:0]    sample,
    input  logic                     avg,
    input  logic [MASK_W-1:0]        mask,
    input  logic [DEST_COUNT*EW-1:0] row_in,
    output logic [DEST_COUNT*EW-1:0] row_out
);

    // entry layout: {value, consumed, count}
    for (genvar d = 0; d < DEST_COUNT; d++)
    begin : g_entry
        logic [DATA_WIDTH-1:0]  val;
        logic                   cons;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [DATA_WIDTH:0]    sum;
        logic [DATA_WIDTH-1:0]  val_next;
        logic                   cons_next;
        logic [COUNT_WIDTH-1:0] cnt_next;
        logic                   sel;

        assign val  = row_in[d*EW+COUNT_WIDTH+1 +: DATA_WIDTH];
        assign cons = row_in[d*EW+COUNT_WIDTH];
        assign cnt  = row_in[d*EW +: COUNT_WIDTH];
        assign sum  = {1'b0, val} + {1'b0, sample};

        if (d < MASK_W)
        begin : g_sel
            assign sel = mask[d];
        end
        else
        begin : g_nosel
            assign sel = 1'b0;
        end

        always_comb
        begin
            val_next  = val;
            cons_next = cons;
            cnt_next  = cnt;
            if (op == OP_SAMPLE)
            begin
                if (cons || !avg || cnt == '0)
                begin
                    val_next  = sample;
                    cons_next = 1'b0;
                    cnt_next  = COUNT_WIDTH'(1);
                end
                else
                begin
                    val_next = sum[DATA_WIDTH:1];
                    if (cnt != '1)
                    begin
                        cnt_next = cnt + COUNT_WIDTH'(1);
                    end
                end
            end
            else
            begin
                cons_next = cons | sel;
            end
        end

        assign row_out[d*EW +: EW] = {val_next, cons_next, cnt_next};
    end

endmodule

// ===== hdl/sensor_destination_average_table.sv =====
// Per-sensor, per-destination averaging table.
// item channel (valid/ready): op 0 is a sample for one sensor and updates all
// destination entries of that sensor (replace or (old+sample)>>1); op 1 is a
// read request whose dest_mask selects destinations.
// result channel (valid/ready): one word per selected destination, in
// ascending destination order, with last on the final word; the entry read
// is marked consumed so the next sample replaces it.
// Timing: one row read and one row write back per item in the table memory.
// Each item is read from the table on acceptance and written back in ST_RMW;
// a read that selects a destination then moves to ST_EMIT, which loads a word
// whenever the result side is ready or holds no word. One item is in progress
// at a time; item.ready is high only when idle. Items for a sensor beyond the
// table are dropped. A stalled result channel holds the current word and pauses
// the walk. Reset clears control state and marks every row empty; empty rows
// read as zero, so no clearing pass is needed.
module sensor_destination_average_table import sdat_pkg::*; #(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int DEST_COUNT   = DEST_COUNT_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sdat_in_if.sink   item,
    sdat_out_if.source result
);

    localparam int EW       = DATA_WIDTH + 1 + COUNT_WIDTH;
    localparam int ROW_W    = DEST_COUNT * EW;
    localparam int AW       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int MASK_USE = (DEST_COUNT < MASK_W) ? DEST_COUNT : MASK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  op_reg;
    logic [AW-1:0]         addr_reg;
    logic [DATA_WIDTH-1:0] sample_reg;
    logic                  avg_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [MASK_W-1:0]     remain_reg, remain_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DEST_W-1:0]     out_dest_reg;
    logic [SAMPLE_W-1:0]   out_value_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  in_range;
    logic                  mem_rd_en;
    logic                  mem_wr_en;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      row_new;
    logic [MASK_W-1:0]     dest_ok;
    logic [MASK_W-1:0]     pick_hot;
    logic [DEST_W-1:0]     pick_idx;
    logic                  pick_found;
    logic [DATA_WIDTH-1:0] pick_value;
    logic                  load_out;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign in_range   = 32'(item.sensor) < 32'(SENSOR_COUNT);
    assign mem_rd_en  = accept && in_range;
    assign mem_wr_en  = (state_reg == ST_RMW);

    sdat_mem #(
        .DEPTH (SENSOR_COUNT),
        .WIDTH (ROW_W),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (AW'(item.sensor)),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg),
        .wr_data (row_new),
        .rd_row  (row)
    );

    sdat_upd #(
        .DEST_COUNT  (DEST_COUNT),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .EW          (EW)
    ) u_upd (
        .op      (op_reg),
        .sample  (sample_reg),
        .avg     (avg_reg),
        .mask    (mask_reg),
        .row_in  (row),
        .row_out (row_new)
    );

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            dest_ok[i] = (i < MASK_USE);
        end
    end

    // lowest remaining destination
    always_comb
    begin
        pick_hot   = '0;
        pick_idx   = '0;
        pick_found = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (!pick_found && remain_reg[i])
            begin
                pick_hot[i] = 1'b1;
                pick_idx    = DEST_W'(i);
                pick_found  = 1'b1;
            end
        end
    end

    always_comb
    begin
        pick_value = '0;
        for (int i = 0; i < MASK_USE; i++)
        begin
            if (pick_hot[i])
            begin
                pick_value = row[i*EW+COUNT_WIDTH+1 +: DATA_WIDTH];
            end
        end
    end

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (mem_rd_en)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                if (op_reg == OP_READ && (mask_reg & dest_ok) != '0)
                begin
                    remain_next = mask_reg & dest_ok;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    remain_next    = remain_reg & ~pick_hot;
                    if ((remain_reg & ~pick_hot) == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= item.op;
            addr_reg   <= AW'(item.sensor);
            sample_reg <= item.sample_value[DATA_WIDTH-1:0];
            avg_reg    <= item.average_enable;
            mask_reg   <= item.dest_mask;
        end
        if (load_out)
        begin
            out_dest_reg  <= pick_idx;
            out_value_reg <= SAMPLE_W'(pick_value);
            out_last_reg  <= ((remain_reg & ~pick_hot) == '0);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.destination = out_dest_reg;
    assign result.read_value  = out_value_reg;
    assign result.last        = out_last_reg;

endmodule
